// ===== rtl/bank_event_statistics_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the bank event statistics checkers
// ----------------------------------------------------------------------------
`ifndef BANK_EVENT_STATISTICS_DEFINES_SVH
`define BANK_EVENT_STATISTICS_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BES_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define BES_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== rtl/bes_pkg.sv =====
// ----------------------------------------------------------------------------
// bes_pkg
// Types and constants for the bank event statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package bes_pkg;

   // defaults for the top-level parameters
   localparam int SECTORS_DEF           = 6;
   localparam int REGIONS_DEF           = 3;
   localparam int LAYERS_PER_REGION_DEF = 12;

   localparam int NUM_DET   = 5;
   localparam int INDEX_W   = 7;
   localparam int SECTOR_W  = 3;
   localparam int REGION_W  = 2;

   // event layout
   localparam int EVENT_LEN_POS = 10;
   localparam int FIRST_BANK    = 11;
   localparam int MIN_HEADER    = 9;

   // offsets inside a bank
   localparam int OFF_NAME   = 1;
   localparam int OFF_SECTOR = 3;
   localparam int OFF_COUNT  = 8;
   localparam int OFF_RUN    = 11;

   localparam logic signed [31:0] MIN_TYPE = 32'sd1;
   localparam logic signed [31:0] MAX_TYPE = 32'sd15;

   // bank names, first character in the top byte
   localparam logic [31:0] NAME_HEAD = 32'h4845_4144;
   localparam logic [31:0] NAME_DC0  = 32'h4443_3020;
   localparam logic [31:0] NAME_EC   = 32'h4543_2020;
   localparam logic [31:0] NAME_SC   = 32'h5343_2020;
   localparam logic [31:0] NAME_CC   = 32'h4343_2020;
   localparam logic [31:0] NAME_EC1  = 32'h4543_3120;

   typedef enum logic [1:0] {
      KIND_EVENT  = 2'd0,
      KIND_READ   = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_IGNORE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      DET_NONE = 3'd0,
      DET_HEAD = 3'd1,
      DET_DC0  = 3'd2,
      DET_EC   = 3'd3,
      DET_SC   = 3'd4,
      DET_CC   = 3'd5,
      DET_EC1  = 3'd6
   } det_type;

   // counter update command handed from the parser stage to the counter stage
   typedef struct packed {
      kind_type              kind;
      logic                  event_inc;
      logic                  bank_en;
      logic [2:0]            bank_det;
      logic [SECTOR_W-1:0]   sector;
      logic [31:0]           data;
      logic                  run_en;
      logic                  hit_a_en;
      logic [REGION_W-1:0]   hit_a_region;
      logic                  hit_b_en;
      logic [REGION_W-1:0]   hit_b_region;
      logic [INDEX_W-1:0]    index;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/bank_event_statistics.sv =====
// ----------------------------------------------------------------------------
// bank_event_statistics
// Walks event words, counts events, banks and data words per detector and
// sector, drift chamber hits per sector and region; answers counter reads.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  req_     | in  | req_valid/stall    | kind, word, first_word, event_type,
//           |     |                    | counter_index
//  rsp_     | out | rsp_valid/stall    | read_value (reads only)
//
//  One item per cycle unless a read waits at the output; a read result is
//  registered in the input register, parser stage and result register.
//  The word position / bank offset update is combinational in the parser.
//  Reset zeroes all counters and parser state.
//  rsp_stall holds only a read sitting in the counter stage; other items
//  keep flowing behind a waiting result until a read reaches that stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_event_statistics
   import bes_pkg::*;
#(
   parameter int SECTORS           = SECTORS_DEF,
   parameter int REGIONS           = REGIONS_DEF,
   parameter int LAYERS_PER_REGION = LAYERS_PER_REGION_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_kind,
   input  wire logic [31:0]         req_word,
   input  wire logic                req_first_word,
   input  wire logic signed [31:0]  req_event_type,
   input  wire logic [INDEX_W-1:0]  req_counter_index,

   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [31:0]              rsp_read_value
);

   localparam int NBANK = NUM_DET * SECTORS;
   localparam int NHIT  = SECTORS * REGIONS;
   localparam int NSTAT = 2 * NBANK + NHIT;

   // ---------------------------------------------------------------- handshake
   logic     s1_valid_ff;
   logic     s2_valid_ff;
   logic     rsp_valid_ff;
   logic     out_free;
   logic     s2_go;
   logic     s2_free;
   logic     s1_go;
   logic     s1_free;
   logic     accept;

   kind_type            s1_kind_ff;
   logic [31:0]         s1_word_ff;
   logic                s1_first_ff;
   logic signed [31:0]  s1_type_ff;
   logic [INDEX_W-1:0]  s1_index_ff;

   cmd_type  cmd_in;
   cmd_type  cmd_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_go     = s2_valid_ff && ((cmd_ff.kind != KIND_READ) || out_free);
   assign s2_free   = !s2_valid_ff || s2_go;
   assign s1_go     = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s1_go;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= kind_type'(req_kind);
         s1_word_ff  <= req_word;
         s1_first_ff <= req_first_word;
         s1_type_ff  <= req_event_type;
         s1_index_ff <= req_counter_index;
      end
   end

   // ---------------------------------------------------------------- parser
   logic [31:0]          pos_ff,   pos_in;
   logic                 active_ff, active_in;
   logic [31:0]          end_ff,   end_in;
   logic [31:0]          off_ff,   off_in;
   logic [30:0]          hlen_ff,  hlen_in;
   logic [31:0]          blen_ff,  blen_in;
   det_type              det_ff,   det_in;
   logic [SECTOR_W-1:0]  sec_ff,   sec_in;
   logic                 secok_ff, secok_in;

   logic [31:0]          off_cur;
   logic [31:0]          off_eff;
   logic                 rebase;
   logic                 stop;
   logic [REGION_W:0]    hit_a;
   logic [REGION_W:0]    hit_b;

   // {valid, region-1} of one 16-bit hit; layer is the signed top byte
   function automatic logic [REGION_W:0] hit_region(input logic [15:0] half);
      logic signed [9:0]    layer;
      logic [REGION_W-1:0]  q;
      logic                 ok;
      layer = {{2{half[15]}}, half[15:8]};
      q     = '0;
      for (int r = 1; r < REGIONS; r++) begin
         if (layer >= $signed(10'(r * LAYERS_PER_REGION))) begin
            q = REGION_W'(r);
         end
      end
      ok = (layer > -$signed(10'(LAYERS_PER_REGION))) &&
           (layer < $signed(10'(REGIONS * LAYERS_PER_REGION)));
      return {ok, q};
   endfunction

   assign hit_a = hit_region(s1_word_ff[31:16]);
   assign hit_b = hit_region(s1_word_ff[15:0]);

   always_comb begin
      pos_in    = pos_ff;
      active_in = active_ff;
      end_in    = end_ff;
      off_in    = off_ff;
      hlen_in   = hlen_ff;
      blen_in   = blen_ff;
      det_in    = det_ff;
      sec_in    = sec_ff;
      secok_in  = secok_ff;
      off_cur   = off_ff + 32'd1;
      rebase    = 1'b0;
      off_eff   = off_cur;
      stop      = 1'b0;

      cmd_in       = '0;
      cmd_in.kind  = s1_kind_ff;
      cmd_in.index = s1_index_ff;
      cmd_in.data  = s1_word_ff;

      if (s1_kind_ff == KIND_EVENT) begin
         if (s1_first_ff) begin
            cmd_in.event_inc = 1'b1;
            pos_in    = '0;
            active_in = (s1_type_ff >= MIN_TYPE) && (s1_type_ff <= MAX_TYPE);
            end_in    = '0;
            hlen_in   = '0;
            blen_in   = '0;
            det_in    = DET_NONE;
            sec_in    = '0;
            secok_in  = 1'b0;
         end else if (pos_ff == '1) begin
            active_in = 1'b0;
         end else begin
            pos_in = pos_ff + 32'd1;
         end

         if (active_in) begin
            if (pos_in == 32'(EVENT_LEN_POS)) begin
               if ((s1_word_ff == '0) || s1_word_ff[31]) begin
                  active_in = 1'b0;
               end else begin
                  end_in = s1_word_ff + 32'(FIRST_BANK);
                  off_in = '1;   // next word is offset zero of the first bank
               end
            end else if (pos_in >= 32'(FIRST_BANK)) begin
               // end of the current bank: the next one starts here
               rebase  = (off_cur >= 32'(MIN_HEADER)) && (off_cur == blen_ff);
               off_eff = rebase ? '0 : off_cur;
               off_in  = off_eff;

               if (off_eff == '0) begin
                  if ((pos_in >= end_in) || s1_word_ff[31] ||
                      (s1_word_ff < 32'(MIN_HEADER))) begin
                     active_in = 1'b0;
                     stop      = 1'b1;
                  end else begin
                     hlen_in  = s1_word_ff[30:0];
                     blen_in  = {1'b0, s1_word_ff[30:0]};
                     det_in   = DET_NONE;
                     sec_in   = '0;
                     secok_in = 1'b0;
                  end
               end else if (off_eff == 32'(OFF_NAME)) begin
                  case (s1_word_ff)
                     NAME_HEAD: det_in = DET_HEAD;
                     NAME_DC0:  det_in = DET_DC0;
                     NAME_EC:   det_in = DET_EC;
                     NAME_SC:   det_in = DET_SC;
                     NAME_CC:   det_in = DET_CC;
                     NAME_EC1:  det_in = DET_EC1;
                     default:   det_in = DET_NONE;
                  endcase
               end else if (off_eff == 32'(OFF_SECTOR)) begin
                  secok_in = (s1_word_ff >= 32'd1) && (s1_word_ff <= 32'(SECTORS));
                  sec_in   = s1_word_ff[SECTOR_W-1:0] - SECTOR_W'(1);
               end else if (off_eff == 32'(OFF_COUNT)) begin
                  if ((s1_word_ff == '0) || s1_word_ff[31]) begin
                     active_in = 1'b0;
                     stop      = 1'b1;
                  end else begin
                     blen_in = 32'(hlen_ff) + 32'(s1_word_ff[30:0]);
                     if ((det_in >= DET_DC0) && secok_in) begin
                        cmd_in.bank_en  = 1'b1;
                        cmd_in.bank_det = 3'(det_in) - 3'(DET_DC0);
                     end
                  end
               end

               if (!stop) begin
                  if ((off_eff == 32'(OFF_RUN)) && (det_in == DET_HEAD)) begin
                     cmd_in.run_en = 1'b1;
                  end
                  if ((off_eff >= 32'(MIN_HEADER)) && (off_eff >= 32'(hlen_in)) &&
                      (det_in == DET_DC0) && secok_in) begin
                     cmd_in.hit_a_en     = hit_a[REGION_W];
                     cmd_in.hit_a_region = hit_a[REGION_W-1:0];
                     cmd_in.hit_b_en     = hit_b[REGION_W];
                     cmd_in.hit_b_region = hit_b[REGION_W-1:0];
                  end
               end
            end
         end
      end
      cmd_in.sector = sec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         active_ff <= 1'b0;
         end_ff    <= '0;
         off_ff    <= '0;
         hlen_ff   <= '0;
         blen_ff   <= '0;
         det_ff    <= DET_NONE;
         sec_ff    <= '0;
         secok_ff  <= 1'b0;
      end else if (s1_go) begin
         pos_ff    <= pos_in;
         active_ff <= active_in;
         end_ff    <= end_in;
         off_ff    <= off_in;
         hlen_ff   <= hlen_in;
         blen_ff   <= blen_in;
         det_ff    <= det_in;
         sec_ff    <= sec_in;
         secok_ff  <= secok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         cmd_ff <= cmd_in;
      end
   end

   // ---------------------------------------------------------------- counters
   logic [31:0]  bank_cnt_ff [NBANK];
   logic [31:0]  word_sum_ff [NBANK];
   logic [31:0]  hit_cnt_ff  [NHIT];
   logic [31:0]  event_cnt_ff;
   logic [31:0]  run_number_ff;
   logic         do_clear;

   assign do_clear = s2_go && (cmd_ff.kind == KIND_CLEAR);

   for (genvar g = 0; g < NBANK; g++) begin : g_bank
      logic sel;
      assign sel = s2_go && cmd_ff.bank_en &&
                   (cmd_ff.bank_det == 3'(g / SECTORS)) &&
                   (cmd_ff.sector == SECTOR_W'(g % SECTORS));

      always_ff @(posedge clock) begin
         if (reset || do_clear) begin
            bank_cnt_ff[g] <= '0;
            word_sum_ff[g] <= '0;
         end else if (sel) begin
            bank_cnt_ff[g] <= bank_cnt_ff[g] + 32'd1;
            word_sum_ff[g] <= word_sum_ff[g] + cmd_ff.data;
         end
      end
   end

   for (genvar g = 0; g < NHIT; g++) begin : g_hit
      logic in_sector;
      logic a_hit;
      logic b_hit;
      assign in_sector = s2_go && (cmd_ff.sector == SECTOR_W'(g / REGIONS));
      assign a_hit = in_sector && cmd_ff.hit_a_en &&
                     (cmd_ff.hit_a_region == REGION_W'(g % REGIONS));
      assign b_hit = in_sector && cmd_ff.hit_b_en &&
                     (cmd_ff.hit_b_region == REGION_W'(g % REGIONS));

      always_ff @(posedge clock) begin
         if (reset || do_clear) begin
            hit_cnt_ff[g] <= '0;
         end else if (a_hit || b_hit) begin
            // both halves of one word may land in the same region
            hit_cnt_ff[g] <= hit_cnt_ff[g] + 32'(a_hit) + 32'(b_hit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         event_cnt_ff <= '0;
      end else if (s2_go && cmd_ff.event_inc) begin
         event_cnt_ff <= event_cnt_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_number_ff <= '0;
      end else if (s2_go && cmd_ff.run_en) begin
         run_number_ff <= cmd_ff.data;
      end
   end

   // ---------------------------------------------------------------- read side
   logic [31:0] read_value;

   always_comb begin
      read_value = '0;
      for (int i = 0; i < NBANK; i++) begin
         if (cmd_ff.index == INDEX_W'(i)) begin
            read_value = bank_cnt_ff[i];
         end
         if (cmd_ff.index == INDEX_W'(NBANK + i)) begin
            read_value = word_sum_ff[i];
         end
      end
      for (int i = 0; i < NHIT; i++) begin
         if (cmd_ff.index == INDEX_W'(2 * NBANK + i)) begin
            read_value = hit_cnt_ff[i];
         end
      end
      if (cmd_ff.index == INDEX_W'(NSTAT)) begin
         read_value = event_cnt_ff;
      end
      if (cmd_ff.index == INDEX_W'(NSTAT + 1)) begin
         read_value = run_number_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_go && (cmd_ff.kind == KIND_READ);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go && (cmd_ff.kind == KIND_READ)) begin
         rsp_read_value <= read_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/bes_checker.sv =====
// ----------------------------------------------------------------------------
// bes_checker
// Port-level checks for bank_event_statistics: read results, in-flight
// reads and input stall cause.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bank_event_statistics_defines.svh"

module bes_checker
   import bes_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire logic [1:0]   req_kind,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire logic [31:0]  rsp_read_value
);

   // reads transferred in but not yet answered
   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       read_acc;
   logic       rsp_xfer;

   assign read_acc   = req_valid && !req_stall && (req_kind == KIND_READ);
   assign rsp_xfer   = rsp_valid && !rsp_stall;
   assign pending_in = pending_ff + 3'(read_acc) - 3'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `BES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_value), "stalled result changed")
   `BES_ASSERT_IMPLY(a_rsp_has_read, clock, reset, rsp_valid, pending_ff != 3'd0, "result without a read")
   `BES_ASSERT_IMPLY(a_pending_bound, clock, reset, 1'b1, pending_ff <= 3'd3, "too many reads in flight")
   `BES_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled with output free")

endmodule

bind bank_event_statistics bes_checker u_bes_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_kind       (req_kind),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_read_value (rsp_read_value)
);

`default_nettype wire
